/* rtl/assert_macros.svh */
// Assertion helpers for the RTL files; kbwg_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define KB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kbwg: property violated");

// Condition must never be seen outside reset.
`define KB_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("kbwg: forbidden condition");

`endif

/* rtl/kbwg_pkg.sv */
package kbwg_pkg;

    localparam logic [31:0] KEY_STEP    = 32'h9E37_79B9;
    localparam logic [31:0] INDEX_MUL   = 32'h06A0_DD9B;
    localparam logic [31:0] FMIX_MUL1   = 32'h85EB_CA6B;
    localparam logic [31:0] FMIX_MUL2   = 32'hC2B2_AE35;
    localparam logic [7:0]  BLOCK_WORDS = 8'd255;
    localparam logic [7:0]  TAP_OFFSET  = 8'd6;

    localparam int QUEUE_DEPTH_DEF = 2;

    // command word passed from the front to the back
    typedef struct packed {
        logic seed;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FMIX,
        ST_DONE
    } state_t;

    // rotate left; a zero amount passes the word through
    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] tmp;
        tmp = {v, v} << s;
        return tmp[63:32];
    endfunction

endpackage

/* rtl/keyed_block_word_generator.sv */
// An accepted push is queued; the back pops it, runs MUL0, MUL1, MUL2 and FMIX for each
// of the two table words, then registers the word in DONE once the output slot is free, and
// empty goes low. Words are made one at a time by the single shared multiplier, in sequence.
// A two-word command queue lets pushes continue while the back is busy.
// Reset (rst_n, async, active low) clears the seed key, the queue and the
// sequencer; the first word after reset always reseeds from the seed key.
module keyed_block_word_generator
#(
    parameter int QUEUE_DEPTH = kbwg_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        restart,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] word,
    output logic        last_of_block,
    input  logic        seed_key_we,
    input  logic [31:0] seed_key_data
);

    logic [31:0]    seed_key_reg;
    logic [31:0]    seed_key_next;
    logic           q_full;
    logic           q_push;
    kbwg_pkg::cmd_t q_entry;
    logic           q_valid;
    kbwg_pkg::cmd_t q_head;
    logic           q_pop;

    assign seed_key_next = seed_key_we ? seed_key_data : seed_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_key_reg <= '0;
        end
        else
        begin
            seed_key_reg <= seed_key_next;
        end
    end

    kbwg_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .restart (restart),
        .full    (full),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    kbwg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .valid   (q_valid)
    );

    kbwg_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_key      (seed_key_reg),
        .cmd_valid     (q_valid),
        .cmd           (q_head),
        .cmd_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .word          (word),
        .last_of_block (last_of_block)
    );

endmodule

/* rtl/kbwg_front.sv */
module kbwg_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            restart,
    output logic            full,
    input  logic            q_full,
    output logic            q_push,
    output kbwg_pkg::cmd_t  q_entry
);

    logic seen_reg;
    logic seen_next;

    assign full    = q_full;
    assign q_push  = push && !q_full;

    // first word after reset always reseeds
    assign q_entry.seed = restart || !seen_reg;

    assign seen_next = seen_reg || q_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

/* rtl/kbwg_queue.sv */
module kbwg_queue
#(
    parameter int DEPTH = kbwg_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  kbwg_pkg::cmd_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output kbwg_pkg::cmd_t  rd_data,
    output logic            valid
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);

    kbwg_pkg::cmd_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/kbwg_back.sv */
`include "assert_macros.svh"

module kbwg_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     seed_key,
    input  logic            cmd_valid,
    input  kbwg_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            empty,
    input  logic            pop,
    output logic [31:0]     word,
    output logic            last_of_block
);

    kbwg_pkg::state_t state_reg;
    kbwg_pkg::state_t state_next;

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [7:0]  d_reg;
    logic [7:0]  d_next;
    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic        jsel_reg;
    logic        jsel_next;
    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] t0_reg;
    logic [31:0] t0_next;
    logic [31:0] t1_reg;
    logic [31:0] t1_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic        last_reg;
    logic        last_next;

    logic [31:0] mul_a;
    logic [31:0] mul_c;
    logic [31:0] prod;
    logic [7:0]  j;
    logic [4:0]  rot_s;
    logic [31:0] rot_out;
    logic [31:0] tw;
    logic [31:0] o;
    logic [31:0] a_new;
    logic [31:0] b_new;
    logic [31:0] w_new;
    logic [31:0] d_ext;
    logic [31:0] key_adv;
    logic        is_last;
    logic        commit;
    logic        wrap_ok;

    // one shared multiplier, product registered in h_reg
    assign prod = mul_a * mul_c;

    // table index: first tap at pos+6, second at pos+7
    assign j       = pos_reg + kbwg_pkg::TAP_OFFSET + {7'b0, jsel_reg};
    assign rot_s   = key_reg[4:0] ^ j[4:0];
    assign rot_out = kbwg_pkg::rotl32(h_reg, rot_s);
    assign tw      = h_reg ^ (h_reg >> 16);

    assign d_ext   = {24'b0, d_reg};
    assign o       = (t0_reg << 6) ^ (t1_reg << 7);
    assign a_new   = (d_ext ^ o) ^ (key_reg + a_reg);
    assign b_new   = (key_reg + a_new) ^ (o + d_ext);
    assign w_new   = kbwg_pkg::rotl32((a_new >> 13) ^ a_new, b_new[4:0]);
    assign key_adv = key_reg + kbwg_pkg::KEY_STEP;
    assign is_last = (pos_reg <= 8'd1);

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        pos_next       = pos_reg;
        jsel_next      = jsel_reg;
        h_next         = h_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !pop;
        mul_a          = '0;
        mul_c          = '0;
        cmd_pop        = 1'b0;
        commit         = 1'b0;

        unique case (state_reg)
            kbwg_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    jsel_next = 1'b0;
                    if (cmd.seed)
                    begin
                        key_next = seed_key;
                        a_next   = seed_key;
                        d_next   = 8'd0;
                        pos_next = kbwg_pkg::BLOCK_WORDS;
                    end
                    state_next = kbwg_pkg::ST_MUL0;
                end
            end
            kbwg_pkg::ST_MUL0:
            begin
                // j*c + key*c == (j + key)*c mod 2^32
                mul_a      = key_reg + {24'b0, j};
                mul_c      = kbwg_pkg::INDEX_MUL;
                h_next     = prod;
                state_next = kbwg_pkg::ST_MUL1;
            end
            kbwg_pkg::ST_MUL1:
            begin
                mul_a      = rot_out ^ (rot_out >> 16);
                mul_c      = kbwg_pkg::FMIX_MUL1;
                h_next     = prod;
                state_next = kbwg_pkg::ST_MUL2;
            end
            kbwg_pkg::ST_MUL2:
            begin
                mul_a      = h_reg ^ (h_reg >> 13);
                mul_c      = kbwg_pkg::FMIX_MUL2;
                h_next     = prod;
                state_next = kbwg_pkg::ST_FMIX;
            end
            kbwg_pkg::ST_FMIX:
            begin
                if (!jsel_reg)
                begin
                    t0_next    = tw;
                    jsel_next  = 1'b1;
                    state_next = kbwg_pkg::ST_MUL0;
                end
                else
                begin
                    t1_next    = tw;
                    state_next = kbwg_pkg::ST_DONE;
                end
            end
            kbwg_pkg::ST_DONE:
            begin
                // hold until the output slot frees up
                if (!out_valid_reg || pop)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    word_next      = w_new;
                    last_next      = is_last;
                    if (is_last)
                    begin
                        key_next = key_adv;
                        a_next   = key_adv;
                        d_next   = 8'd0;
                        pos_next = kbwg_pkg::BLOCK_WORDS;
                    end
                    else
                    begin
                        a_next   = a_new;
                        d_next   = w_new[7:0];
                        pos_next = pos_reg - 8'd1;
                    end
                    state_next = kbwg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kbwg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kbwg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            a_reg         <= '0;
            d_reg         <= '0;
            pos_reg       <= kbwg_pkg::BLOCK_WORDS;
            jsel_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
            a_reg         <= a_next;
            d_reg         <= d_next;
            pos_reg       <= pos_next;
            jsel_reg      <= jsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign empty         = !out_valid_reg;
    assign word          = word_reg;
    assign last_of_block = last_reg;

    // state of a freshly loaded key block
    assign wrap_ok = (pos_reg == kbwg_pkg::BLOCK_WORDS) && (d_reg == 8'd0) && (a_reg == key_reg);

    `KB_NEVER(a_pos_zero, clk, rst_n, pos_reg == 8'd0)
    `KB_ASSERT(a_block_wrap, clk, rst_n, (commit && pos_reg == 8'd1) |=> wrap_ok)
    `KB_ASSERT(a_idle_hold, clk, rst_n, (state_reg == kbwg_pkg::ST_IDLE && !cmd_valid) |=> (state_reg == kbwg_pkg::ST_IDLE))

endmodule
